>>> rtl/gas_pkg.sv
// shared types and codes for the grid a* search core
package gas_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [2:0] CELL_EMPTY    = 3'd0;
    localparam logic [2:0] CELL_OBSTACLE = 3'd1;
    localparam logic [2:0] CELL_CLOSED   = 3'd2;
    localparam logic [2:0] CELL_PATH     = 3'd3;
    localparam logic [2:0] CELL_START    = 3'd4;
    localparam logic [2:0] CELL_FINISH   = 3'd5;

    localparam logic [2:0] REG_GRID_ROWS = 3'd0;
    localparam logic [2:0] REG_GRID_COLS = 3'd1;
    localparam logic [2:0] REG_START_ROW = 3'd2;
    localparam logic [2:0] REG_START_COL = 3'd3;
    localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] REG_GOAL_COL  = 3'd5;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] row;
        logic [3:0] col;
        logic       obstacle;
    } t_in;

    typedef struct packed {
        logic [2:0] cell_state;
        logic       found;
        logic [8:0] expanded_count;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_INIT,
        S_START,
        S_SCAN,
        S_POP,
        S_GOAL1,
        S_GOAL2,
        S_NBR,
        S_CHK,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic in_take;
        logic res_imm;
        logic res_read;
        logic res_search;
        logic srch_init;
        logic add_start;
        logic scan_init;
        logic scan_step;
        logic pop;
        logic mark_start;
        logic mark_goal;
        logic nbr_issue;
        logic nbr_add;
        logic dir_next;
    } t_dp_ctl;

    typedef struct packed {
        logic clr_done;
        logic start_ok;
        logic scan_done;
        logic best_is_goal;
        logic nbr_inb;
        logic nbr_empty;
        logic dir_last;
        logic open_empty;
    } t_dp_sts;

endpackage

>>> rtl/grid_astar_search_core.sv
// Grid A* search core: four-neighbour search with a Manhattan heuristic over a
// MAX_ROWS x MAX_COLS cell store. After reset the core clears its cell store,
// one cell per cycle, and takes no command until then. A cell write or an
// unused command loads its result from the idle state, a cell read loads it
// from S_READ after the registered store read. A search sets up in S_INIT and
// S_START (S_INIT goes straight to S_DONE when the start lies outside the
// grid), then for every expansion scans the open list, all entries added so
// far, at one entry per cycle and takes the best entry in S_POP; an expansion
// that is not the goal checks the four neighbours in S_NBR and S_CHK and loops
// through S_NEXT, which ends the search when the open list is empty, and the
// goal gets its start and finish marks in S_GOAL1 and S_GOAL2. Each command
// gives one result beat, held in an output register until taken; the input
// stalls while a command runs and while that register holds a beat that is not being taken.
module grid_astar_search_core #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  gas_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output gas_pkg::t_out o_out_data,
    input  logic          i_out_stall,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [4:0] r_grid_rows;
    logic [4:0] r_grid_cols;
    logic [3:0] r_start_row;
    logic [3:0] r_start_col;
    logic [3:0] r_goal_row;
    logic [3:0] r_goal_col;

    gas_pkg::t_dp_ctl ctl;
    gas_pkg::t_dp_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= 5'd16;
            r_grid_cols <= 5'd16;
            r_start_row <= '0;
            r_start_col <= '0;
            r_goal_row  <= '0;
            r_goal_col  <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                gas_pkg::REG_GRID_ROWS: r_grid_rows <= pwdata[4:0];
                gas_pkg::REG_GRID_COLS: r_grid_cols <= pwdata[4:0];
                gas_pkg::REG_START_ROW: r_start_row <= pwdata[3:0];
                gas_pkg::REG_START_COL: r_start_col <= pwdata[3:0];
                gas_pkg::REG_GOAL_ROW:  r_goal_row  <= pwdata[3:0];
                gas_pkg::REG_GOAL_COL:  r_goal_col  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gas_pkg::REG_GRID_ROWS: prdata = 32'(r_grid_rows);
            gas_pkg::REG_GRID_COLS: prdata = 32'(r_grid_cols);
            gas_pkg::REG_START_ROW: prdata = 32'(r_start_row);
            gas_pkg::REG_START_COL: prdata = 32'(r_start_col);
            gas_pkg::REG_GOAL_ROW:  prdata = 32'(r_goal_row);
            gas_pkg::REG_GOAL_COL:  prdata = 32'(r_goal_col);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    gas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    gas_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .i_start_row (r_start_row),
        .i_start_col (r_start_col),
        .i_goal_row  (r_goal_row),
        .i_goal_col  (r_goal_col),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/gas_dp.sv
// datapath: cell store, open list memory, scan and neighbor logic
module gas_dp #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gas_pkg::t_dp_ctl i_ctl,
    output gas_pkg::t_dp_sts o_sts,
    input  gas_pkg::t_in     i_in_data,
    input  logic [4:0]       i_grid_rows,
    input  logic [4:0]       i_grid_cols,
    input  logic [3:0]       i_start_row,
    input  logic [3:0]       i_start_col,
    input  logic [3:0]       i_goal_row,
    input  logic [3:0]       i_goal_col,
    output gas_pkg::t_out    o_out_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IW    = $clog2(CELLS);
    localparam int GW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int MW    = (RW > CW) ? RW : CW;
    localparam int DW    = ((MW > 4) ? MW : 4) + 1;
    localparam int HW    = DW + 1;
    localparam int FW    = ((GW > HW) ? GW : HW) + 1;
    localparam int EW    = 1 + RW + CW + GW + FW;

    function automatic logic [HW-1:0] f_dist(input logic [DW-1:0] a, input logic [DW-1:0] b);
        f_dist = (a > b) ? HW'(a - b) : HW'(b - a);
    endfunction

    function automatic logic [IW-1:0] f_idx(input logic [RW-1:0] r, input logic [CW-1:0] c);
        f_idx = IW'(IW'(r) * IW'(MAX_COLS) + IW'(c));
    endfunction

    logic [2:0]    r_cell_mem [CELLS];
    logic [2:0]    r_cell_q;
    logic [EW-1:0] r_open_mem [CELLS];
    logic [EW-1:0] r_open_q;

    logic [IW-1:0] r_clr_idx;
    logic [GW-1:0] r_adds;
    logic [GW-1:0] r_live;
    logic [GW-1:0] r_pops;
    logic [GW-1:0] r_scan_idx;
    logic          r_rd_pend;
    logic [IW-1:0] r_rd_idx;
    logic          r_have_best;
    logic          r_found;
    logic          r_rd_inside;
    logic [1:0]    r_dir;
    logic [RW-1:0] r_best_r;
    logic [CW-1:0] r_best_c;
    logic [GW-1:0] r_best_g;
    logic [FW-1:0] r_best_f;
    logic [IW-1:0] r_best_idx;
    gas_pkg::t_out r_out;

    logic [DW-1:0] rows_eff, cols_eff;
    logic [DW-1:0] in_r, in_c, st_r, st_c, gl_r, gl_c;
    logic          in_inside;
    logic [IW-1:0] in_idx, st_idx, nb_idx, best_cell_idx;
    logic [FW-1:0] st_f;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic          nb_inb;
    logic [GW-1:0] nb_g;
    logic [FW-1:0] nb_f;
    logic          q_live;
    logic [RW-1:0] q_r;
    logic [CW-1:0] q_c;
    logic [GW-1:0] q_g;
    logic [FW-1:0] q_f;
    logic          scan_issue;

    logic          cell_we, cell_re;
    logic [IW-1:0] cell_waddr, cell_raddr;
    logic [2:0]    cell_wdata;
    logic          open_we;
    logic [IW-1:0] open_waddr;
    logic [EW-1:0] open_wdata;

    always_comb begin
        rows_eff = (DW'(i_grid_rows) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(i_grid_rows);
        cols_eff = (DW'(i_grid_cols) > DW'(MAX_COLS)) ? DW'(MAX_COLS) : DW'(i_grid_cols);
        in_r = DW'(i_in_data.row);
        in_c = DW'(i_in_data.col);
        st_r = DW'(i_start_row);
        st_c = DW'(i_start_col);
        gl_r = DW'(i_goal_row);
        gl_c = DW'(i_goal_col);
        in_inside = (in_r < DW'(MAX_ROWS)) && (in_c < DW'(MAX_COLS));
        in_idx = f_idx(in_r[RW-1:0], in_c[CW-1:0]);
        st_idx = f_idx(st_r[RW-1:0], st_c[CW-1:0]);
        st_f   = FW'(f_dist(st_r, gl_r) + f_dist(st_c, gl_c));
        best_cell_idx = f_idx(r_best_r, r_best_c);

        q_live = r_open_q[EW-1];
        q_r    = r_open_q[EW-2 -: RW];
        q_c    = r_open_q[EW-2-RW -: CW];
        q_g    = r_open_q[FW +: GW];
        q_f    = r_open_q[FW-1:0];

        nb_r   = r_best_r;
        nb_c   = r_best_c;
        nb_inb = 1'b0;
        case (r_dir)
            2'd0: begin
                nb_r   = r_best_r - RW'(1);
                nb_inb = (r_best_r != '0);
            end
            2'd1: begin
                nb_c   = r_best_c - CW'(1);
                nb_inb = (r_best_c != '0);
            end
            2'd2: begin
                nb_r   = r_best_r + RW'(1);
                nb_inb = (DW'(r_best_r) + DW'(1)) < rows_eff;
            end
            default: begin
                nb_c   = r_best_c + CW'(1);
                nb_inb = (DW'(r_best_c) + DW'(1)) < cols_eff;
            end
        endcase
        nb_idx = f_idx(nb_r, nb_c);
        nb_g   = r_best_g + GW'(1);
        nb_f   = FW'(nb_g) + FW'(f_dist(DW'(nb_r), gl_r) + f_dist(DW'(nb_c), gl_c));

        scan_issue = i_ctl.scan_step && (r_scan_idx < r_adds);

        o_sts.clr_done     = (r_clr_idx == IW'(CELLS - 1));
        o_sts.start_ok     = (st_r < rows_eff) && (st_c < cols_eff);
        o_sts.scan_done    = (r_scan_idx == r_adds) && !r_rd_pend;
        o_sts.best_is_goal = (DW'(r_best_r) == gl_r) && (DW'(r_best_c) == gl_c);
        o_sts.nbr_inb      = nb_inb;
        o_sts.nbr_empty    = (r_cell_q == gas_pkg::CELL_EMPTY);
        o_sts.dir_last     = (r_dir == 2'd3);
        o_sts.open_empty   = (r_live == '0);
    end

    // cell store and open list port selection
    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = r_clr_idx;
        cell_wdata = gas_pkg::CELL_EMPTY;
        if (i_ctl.clr_step) begin
            cell_we = 1'b1;
        end else if (i_ctl.in_take && i_in_data.cmd == gas_pkg::CMD_WRITE && in_inside) begin
            cell_we    = 1'b1;
            cell_waddr = in_idx;
            cell_wdata = i_in_data.obstacle ? gas_pkg::CELL_OBSTACLE : gas_pkg::CELL_EMPTY;
        end else if (i_ctl.add_start) begin
            cell_we    = 1'b1;
            cell_waddr = st_idx;
            cell_wdata = gas_pkg::CELL_CLOSED;
        end else if (i_ctl.pop) begin
            cell_we    = 1'b1;
            cell_waddr = best_cell_idx;
            cell_wdata = gas_pkg::CELL_PATH;
        end else if (i_ctl.mark_start) begin
            cell_we    = 1'b1;
            cell_waddr = st_idx;
            cell_wdata = gas_pkg::CELL_START;
        end else if (i_ctl.mark_goal) begin
            cell_we    = 1'b1;
            cell_waddr = best_cell_idx;
            cell_wdata = gas_pkg::CELL_FINISH;
        end else if (i_ctl.nbr_add) begin
            cell_we    = 1'b1;
            cell_waddr = nb_idx;
            cell_wdata = gas_pkg::CELL_CLOSED;
        end

        cell_re    = i_ctl.nbr_issue;
        cell_raddr = nb_idx;
        if (i_ctl.in_take && i_in_data.cmd == gas_pkg::CMD_READ) begin
            cell_re    = 1'b1;
            cell_raddr = in_idx;
        end

        open_we    = 1'b0;
        open_waddr = r_adds[IW-1:0];
        open_wdata = {1'b1, nb_r, nb_c, nb_g, nb_f};
        if (i_ctl.add_start) begin
            open_we    = 1'b1;
            open_wdata = {1'b1, st_r[RW-1:0], st_c[CW-1:0], GW'(0), st_f};
        end else if (i_ctl.nbr_add) begin
            open_we = 1'b1;
        end else if (i_ctl.pop) begin
            // removal clears the live bit, leaving insertion order intact
            open_we    = 1'b1;
            open_waddr = r_best_idx;
            open_wdata = {1'b0, r_best_r, r_best_c, r_best_g, r_best_f};
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re) begin
            r_cell_q <= r_cell_mem[cell_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (open_we) begin
            r_open_mem[open_waddr] <= open_wdata;
        end
        if (scan_issue) begin
            r_open_q <= r_open_mem[r_scan_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_adds      <= '0;
            r_live      <= '0;
            r_pops      <= '0;
            r_scan_idx  <= '0;
            r_rd_pend   <= 1'b0;
            r_have_best <= 1'b0;
            r_found     <= 1'b0;
            r_dir       <= '0;
        end else begin
            if (i_ctl.clr_step) begin
                r_clr_idx <= r_clr_idx + IW'(1);
            end
            if (i_ctl.srch_init) begin
                r_adds  <= '0;
                r_live  <= '0;
                r_pops  <= '0;
                r_found <= 1'b0;
            end
            if (i_ctl.add_start || i_ctl.nbr_add) begin
                r_adds <= r_adds + GW'(1);
                r_live <= r_live + GW'(1);
            end
            if (i_ctl.pop) begin
                r_live <= r_live - GW'(1);
                r_pops <= r_pops + GW'(1);
                r_dir  <= '0;
            end
            if (i_ctl.dir_next) begin
                r_dir <= r_dir + 2'd1;
            end
            if (i_ctl.mark_goal) begin
                r_found <= 1'b1;
            end
            if (i_ctl.scan_init) begin
                r_scan_idx  <= '0;
                r_rd_pend   <= 1'b0;
                r_have_best <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_rd_pend <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + GW'(1);
                end
                // later entries win ties
                if (r_rd_pend && q_live && (!r_have_best || q_f <= r_best_f)) begin
                    r_have_best <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_rd_idx <= r_scan_idx[IW-1:0];
        end
        if (i_ctl.scan_step && r_rd_pend && q_live && (!r_have_best || q_f <= r_best_f)) begin
            r_best_r   <= q_r;
            r_best_c   <= q_c;
            r_best_g   <= q_g;
            r_best_f   <= q_f;
            r_best_idx <= r_rd_idx;
        end
        if (i_ctl.in_take) begin
            r_rd_inside <= in_inside;
        end
        if (i_ctl.res_imm) begin
            r_out.cell_state     <= (i_in_data.cmd == gas_pkg::CMD_WRITE && in_inside) ?
                                    (i_in_data.obstacle ? gas_pkg::CELL_OBSTACLE
                                                        : gas_pkg::CELL_EMPTY)
                                    : gas_pkg::CELL_EMPTY;
            r_out.found          <= 1'b0;
            r_out.expanded_count <= '0;
        end else if (i_ctl.res_read) begin
            r_out.cell_state     <= r_rd_inside ? r_cell_q : gas_pkg::CELL_EMPTY;
            r_out.found          <= 1'b0;
            r_out.expanded_count <= '0;
        end else if (i_ctl.res_search) begin
            r_out.cell_state     <= gas_pkg::CELL_EMPTY;
            r_out.found          <= r_found;
            r_out.expanded_count <= 9'(r_pops);
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/gas_ctrl.sv
// controller: command sequencing and search state machine
module gas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output gas_pkg::t_dp_ctl o_ctl,
    input  gas_pkg::t_dp_sts i_sts
);

    gas_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            accept;
    logic            load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gas_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = !((r_state == gas_pkg::S_IDLE) && (!r_out_valid || !i_out_stall));
        accept     = i_in_valid && !o_in_stall;

        case (r_state)
            gas_pkg::S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = gas_pkg::S_IDLE;
                end
            end
            gas_pkg::S_IDLE: begin
                if (accept) begin
                    o_ctl.in_take = 1'b1;
                    case (i_in_cmd)
                        gas_pkg::CMD_READ:   n_state = gas_pkg::S_READ;
                        gas_pkg::CMD_SEARCH: n_state = gas_pkg::S_INIT;
                        default:             o_ctl.res_imm = 1'b1;
                    endcase
                end
            end
            gas_pkg::S_READ: begin
                o_ctl.res_read = 1'b1;
                n_state        = gas_pkg::S_IDLE;
            end
            gas_pkg::S_INIT: begin
                o_ctl.srch_init = 1'b1;
                n_state = i_sts.start_ok ? gas_pkg::S_START : gas_pkg::S_DONE;
            end
            gas_pkg::S_START: begin
                o_ctl.add_start = 1'b1;
                o_ctl.scan_init = 1'b1;
                n_state         = gas_pkg::S_SCAN;
            end
            gas_pkg::S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = gas_pkg::S_POP;
                end
            end
            gas_pkg::S_POP: begin
                o_ctl.pop = 1'b1;
                n_state = i_sts.best_is_goal ? gas_pkg::S_GOAL1 : gas_pkg::S_NBR;
            end
            gas_pkg::S_GOAL1: begin
                o_ctl.mark_start = 1'b1;
                n_state          = gas_pkg::S_GOAL2;
            end
            gas_pkg::S_GOAL2: begin
                o_ctl.mark_goal = 1'b1;
                n_state         = gas_pkg::S_DONE;
            end
            gas_pkg::S_NBR: begin
                if (i_sts.nbr_inb) begin
                    o_ctl.nbr_issue = 1'b1;
                    n_state         = gas_pkg::S_CHK;
                end else if (i_sts.dir_last) begin
                    n_state = gas_pkg::S_NEXT;
                end else begin
                    o_ctl.dir_next = 1'b1;
                end
            end
            gas_pkg::S_CHK: begin
                o_ctl.nbr_add = i_sts.nbr_empty;
                if (i_sts.dir_last) begin
                    n_state = gas_pkg::S_NEXT;
                end else begin
                    o_ctl.dir_next = 1'b1;
                    n_state        = gas_pkg::S_NBR;
                end
            end
            gas_pkg::S_NEXT: begin
                if (i_sts.open_empty) begin
                    n_state = gas_pkg::S_DONE;
                end else begin
                    o_ctl.scan_init = 1'b1;
                    n_state         = gas_pkg::S_SCAN;
                end
            end
            gas_pkg::S_DONE: begin
                o_ctl.res_search = 1'b1;
                n_state          = gas_pkg::S_IDLE;
            end
            default: begin
                n_state = gas_pkg::S_IDLE;
            end
        endcase

        load = o_ctl.res_imm || o_ctl.res_read || o_ctl.res_search;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
